FILE: sv/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the task-space PD controller
// Request and result layouts, gain registers, CORDIC and friction tables.
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int CORDIC_STEPS = 16;

	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [16:0] PI_Q13          = 17'sd25736;
	localparam logic signed [16:0] HALF_PI_Q13     = 17'sd12868;
	localparam logic signed [33:0] LINK_Q16        = 34'sd16646;
	localparam logic signed [15:0] TORQUE_LIMIT    = 16'sd20480;
	localparam logic signed [33:0] RECIP3_Q31      = 34'sd715827883;

	localparam logic [2:0] REG_GAIN_P_X = 3'd0;
	localparam logic [2:0] REG_GAIN_P_Y = 3'd1;
	localparam logic [2:0] REG_GAIN_P_Z = 3'd2;
	localparam logic [2:0] REG_GAIN_D_X = 3'd3;
	localparam logic [2:0] REG_GAIN_D_Y = 3'd4;
	localparam logic [2:0] REG_GAIN_D_Z = 3'd5;

	typedef struct packed {
		logic signed [15:0] joint_angle_a;
		logic signed [15:0] joint_angle_b;
		logic signed [15:0] joint_angle_c;
		logic signed [15:0] target_x;
		logic signed [15:0] target_y;
		logic signed [15:0] target_z;
		logic signed [31:0] target_vel_x;
		logic signed [31:0] target_vel_y;
		logic signed [31:0] target_vel_z;
	} in_req_t;

	typedef struct packed {
		logic signed [15:0] torque_a;
		logic signed [15:0] torque_b;
		logic signed [15:0] torque_c;
		logic signed [15:0] tip_x;
		logic signed [15:0] tip_y;
		logic signed [15:0] tip_z;
	} out_res_t;

	typedef struct packed {
		logic [15:0] gain_p_x;
		logic [15:0] gain_p_y;
		logic [15:0] gain_p_z;
		logic [15:0] gain_d_x;
		logic [15:0] gain_d_y;
		logic [15:0] gain_d_z;
	} gains_t;

	typedef struct packed {
		logic               done;
		logic signed [17:0] sin_val;
		logic signed [17:0] cos_val;
	} cord_res_t;

	typedef struct packed {
		logic signed [19:0] thr;
		logic signed [19:0] slope;
		logic signed [19:0] vp;
		logic signed [19:0] vn;
		logic signed [19:0] cp;
		logic signed [19:0] cn;
		logic signed [19:0] coeff;
	} fric_par_t;

	function automatic logic [31:0] atan_val(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h3243F6A8;
			5'd1:  r = 32'h1DAC6705;
			5'd2:  r = 32'h0FADBAFC;
			5'd3:  r = 32'h07F56EA6;
			5'd4:  r = 32'h03FEAB76;
			5'd5:  r = 32'h01FFD55B;
			5'd6:  r = 32'h00FFFAAA;
			5'd7:  r = 32'h007FFF55;
			5'd8:  r = 32'h003FFFEA;
			5'd9:  r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic fric_par_t fric_par(input logic [1:0] j);
		fric_par_t r;
		case (j)
			2'd0: r = '{20'sd819, 20'sd235930, 20'sd16469, 20'sd16233,
				20'sd23835, 20'sd19320, 20'sd58982};
			2'd1: r = '{20'sd410, 20'sd235930, 20'sd16384, 20'sd18809,
				20'sd31189, 20'sd32971, 20'sd49152};
			default: r = '{20'sd410, 20'sd235930, 20'sd12596, 20'sd13972,
				20'sd23075, 20'sd23252, 20'sd65536};
		endcase
		return r;
	endfunction

endpackage

FILE: sv/tsp_mul.sv
// ----------------------------------------------------------------------------
// tsp_mul: shared signed multiplier
// One 34x34 bit signed product per cycle while en is high, output registered.
// ----------------------------------------------------------------------------
module tsp_mul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] op_a,
	input  logic signed [33:0] op_b,
	output logic signed [67:0] prod
);
	logic signed [67:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= op_a * op_b;
		end
	end

	assign prod = prod_q;

endmodule

FILE: sv/tsp_cordic.sv
// ----------------------------------------------------------------------------
// tsp_cordic: iterative CORDIC sine and cosine
// Reduces the angle into the half turn around zero, then runs one rotation
// step per cycle with a shared shifter and adder. Results are Q15.
// ----------------------------------------------------------------------------
module tsp_cordic (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [15:0]      angle,
	output tsp_pkg::cord_res_t      res
);
	import tsp_pkg::*;

	logic               busy_q, done_q;
	logic [4:0]         i_q;
	logic signed [33:0] x_q, y_q;
	logic signed [34:0] z_q;
	logic               neg_q;

	logic signed [16:0] ang_ext, ang_red;
	logic               red_neg;
	logic signed [33:0] xs, ys, xn, yn, xr, yr;
	logic signed [34:0] at;
	logic               last;

	always_comb begin
		ang_ext = 17'(angle);
		ang_red = ang_ext;
		red_neg = 1'b0;
		if (ang_ext > HALF_PI_Q13) begin
			ang_red = ang_ext - PI_Q13;
			red_neg = 1'b1;
		end else if (ang_ext < -HALF_PI_Q13) begin
			ang_red = ang_ext + PI_Q13;
			red_neg = 1'b1;
		end
	end

	assign xs   = x_q >>> i_q;
	assign ys   = y_q >>> i_q;
	assign at   = signed'({3'b000, atan_val(i_q)});
	assign last = (i_q == 5'(CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
				end
				i_q <= i_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN_Q30;
			y_q   <= '0;
			z_q   <= 35'(ang_red) <<< 17;
			neg_q <= red_neg;
		end else if (busy_q) begin
			if (!z_q[34]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign xn = neg_q ? -x_q : x_q;
	assign yn = neg_q ? -y_q : y_q;
	assign xr = xn + 34'sd16384;
	assign yr = yn + 34'sd16384;

	assign res.done    = done_q;
	assign res.cos_val = xr[32:15];
	assign res.sin_val = yr[32:15];

endmodule

FILE: sv/tsp_cfg.sv
// ----------------------------------------------------------------------------
// tsp_cfg: gain register file
// Six 16-bit task-space gains behind a bus port with a setup and an access
// phase. Writes beyond the last register are dropped.
// ----------------------------------------------------------------------------
module tsp_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output tsp_pkg::gains_t     gains
);
	import tsp_pkg::*;

	gains_t     gains_q;
	logic       wr;
	logic [2:0] reg_idx;

	assign wr      = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '{16'd25600, 16'd51200, 16'd51200, 16'd1024, 16'd1536, 16'd1536};
		end else if (wr) begin
			unique case (reg_idx)
				REG_GAIN_P_X: gains_q.gain_p_x <= pwdata[15:0];
				REG_GAIN_P_Y: gains_q.gain_p_y <= pwdata[15:0];
				REG_GAIN_P_Z: gains_q.gain_p_z <= pwdata[15:0];
				REG_GAIN_D_X: gains_q.gain_d_x <= pwdata[15:0];
				REG_GAIN_D_Y: gains_q.gain_d_y <= pwdata[15:0];
				REG_GAIN_D_Z: gains_q.gain_d_z <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GAIN_P_X: prdata = {16'd0, gains_q.gain_p_x};
			REG_GAIN_P_Y: prdata = {16'd0, gains_q.gain_p_y};
			REG_GAIN_P_Z: prdata = {16'd0, gains_q.gain_p_z};
			REG_GAIN_D_X: prdata = {16'd0, gains_q.gain_d_x};
			REG_GAIN_D_Y: prdata = {16'd0, gains_q.gain_d_y};
			REG_GAIN_D_Z: prdata = {16'd0, gains_q.gain_d_z};
			default:      prdata = '0;
		endcase
	end

	assign gains = gains_q;

endmodule

FILE: sv/task_space_pd_with_friction_comp.sv
// ----------------------------------------------------------------------------
// task_space_pd_with_friction_comp: task-space PD control with friction
// The shared multiplier is registered: each product is issued in the first
// phase of a sequencer state and captured in the second. The CORDIC unit
// runs one rotation step per cycle. One request is in work at a time; the
// next is taken once the result is handed to the output register.
// Reset clears the gains to their defaults and all speed history to zero.
// ----------------------------------------------------------------------------
module task_space_pd_with_friction_comp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tsp_pkg::in_req_t   in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output tsp_pkg::out_res_t  out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import tsp_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_JRAW = 4'd1;
	localparam logic [3:0] S_JDIV = 4'd2;
	localparam logic [3:0] S_FRU  = 4'd3;
	localparam logic [3:0] S_FRH  = 4'd4;
	localparam logic [3:0] S_FRL  = 4'd5;
	localparam logic [3:0] S_CORD = 4'd6;
	localparam logic [3:0] S_GEO  = 4'd7;
	localparam logic [3:0] S_TRAW = 4'd8;
	localparam logic [3:0] S_TDIV = 4'd9;
	localparam logic [3:0] S_FP   = 4'd10;
	localparam logic [3:0] S_FD   = 4'd11;
	localparam logic [3:0] S_TAU  = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	localparam logic [3:0] G_TC  = 4'd0;
	localparam logic [3:0] G_TS  = 4'd1;
	localparam logic [3:0] G_P0  = 4'd2;
	localparam logic [3:0] G_P1  = 4'd3;
	localparam logic [3:0] G_P2  = 4'd4;
	localparam logic [3:0] G_J10 = 4'd5;
	localparam logic [3:0] G_J11 = 4'd6;
	localparam logic [3:0] G_J12 = 4'd7;
	localparam logic [3:0] G_J20 = 4'd8;
	localparam logic [3:0] G_J21 = 4'd9;
	localparam logic [3:0] G_J22 = 4'd10;

	localparam logic [1:0] LAST_IDX = 2'd2;

	function automatic logic signed [71:0] rnd(input logic signed [71:0] v,
		input int unsigned n);
		logic signed [71:0] bias;
		bias = 72'sd1 <<< (n - 1);
		return (v + bias) >>> n;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = 16'(v);
		end
		return r;
	endfunction

	// Control state.
	logic [3:0] state_q, state_d;
	logic       ph_q, ph_d;
	logic [1:0] idx_q, idx_d;
	logic [3:0] sub_q, sub_d;
	logic       out_valid_q;
	logic       load;

	// Stored history.
	logic signed [15:0] lja_q [3];
	logic signed [31:0] jh0_q [3];
	logic signed [31:0] jh1_q [3];
	logic signed [15:0] ltp_q [3];
	logic signed [31:0] th0_q [3];
	logic signed [31:0] th1_q [3];

	// Working registers.
	in_req_t            req_q;
	out_res_t           out_q;
	logic signed [31:0] s_q, w_q;
	logic signed [46:0] u_q;
	logic signed [71:0] acc_q;
	logic signed [31:0] fr_q [3];
	logic signed [17:0] sn_q [3];
	logic signed [17:0] cs_q [3];
	logic signed [33:0] tc_q, ts_q;
	logic signed [17:0] p_q [3];
	logic signed [17:0] jt1_q [3];
	logic signed [17:0] jt2_q [3];
	logic signed [31:0] v_q [3];
	logic signed [31:0] f_q [3];
	logic signed [15:0] tau_q [3];

	gains_t             gains;
	cord_res_t          cord;
	logic               cord_start;
	logic               mul_en;
	logic signed [33:0] op_a, op_b;
	logic signed [67:0] prod;
	logic signed [71:0] prod_x;

	logic signed [15:0] th_v [3];
	logic signed [15:0] tg_v, ps_v;
	logic signed [31:0] tv_v;
	logic [15:0]        kp_v, kd_v;
	fric_par_t          fp;
	logic signed [16:0] dth, dtp, dtg;
	logic signed [32:0] dtv;
	logic [31:0]        s_abs, div_q;
	logic [32:0]        div_m;
	logic signed [31:0] div_w;
	logic               fr_pos, fr_neg;
	logic signed [46:0] fr_cterm;
	logic signed [18:0] sa, sb;
	logic signed [17:0] jt_v;
	logic signed [71:0] fd_r, tau_base, tau_sum, tau_r;

	tsp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	tsp_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.op_a (op_a),
		.op_b (op_b),
		.prod (prod)
	);

	tsp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.angle  (th_v[idx_q]),
		.res    (cord)
	);

	assign prod_x = 72'(prod);

	assign th_v[0] = req_q.joint_angle_a;
	assign th_v[1] = req_q.joint_angle_b;
	assign th_v[2] = req_q.joint_angle_c;

	always_comb begin
		case (idx_q)
			2'd0: begin
				tg_v = req_q.target_x;
				tv_v = req_q.target_vel_x;
				kp_v = gains.gain_p_x;
				kd_v = gains.gain_d_x;
			end
			2'd1: begin
				tg_v = req_q.target_y;
				tv_v = req_q.target_vel_y;
				kp_v = gains.gain_p_y;
				kd_v = gains.gain_d_y;
			end
			default: begin
				tg_v = req_q.target_z;
				tv_v = req_q.target_vel_z;
				kp_v = gains.gain_p_z;
				kd_v = gains.gain_d_z;
			end
		endcase
	end

	assign fp    = fric_par(idx_q);
	assign ps_v  = sat16(p_q[idx_q]);
	assign dth   = 17'(th_v[idx_q]) - 17'(lja_q[idx_q]);
	assign dtp   = 17'(ps_v) - 17'(ltp_q[idx_q]);
	assign dtg   = 17'(tg_v) - 17'(ps_v);
	assign dtv   = 33'(tv_v) - 33'(v_q[idx_q]);

	// Rounded division by three through a reciprocal, magnitude rounded.
	assign s_abs = s_q[31] ? 32'(-s_q) : 32'(s_q);
	assign div_m = {1'b0, s_abs} + 33'd1;
	assign div_q = prod[62:31];
	assign div_w = s_q[31] ? -signed'(div_q) : signed'(div_q);

	assign fr_pos   = w_q > 32'(fp.thr);
	assign fr_neg   = w_q < -32'(fp.thr);
	assign fr_cterm = fr_pos ? (47'(fp.cp) <<< 13) :
		(fr_neg ? -(47'(fp.cn) <<< 13) : 47'sd0);

	assign sa = 19'(cs_q[2]) + 19'(sn_q[1]);
	assign sb = 19'(cs_q[1]) - 19'(sn_q[2]);

	always_comb begin
		case (idx_q)
			2'd0: begin
				case (sub_q[1:0])
					2'd0:    jt_v = -p_q[1];
					2'd1:    jt_v = p_q[0];
					default: jt_v = '0;
				endcase
			end
			2'd1:    jt_v = jt1_q[sub_q[1:0]];
			default: jt_v = jt2_q[sub_q[1:0]];
		endcase
	end

	assign fd_r     = rnd(acc_q + prod_x, 10);
	assign tau_base = (sub_q == 4'd0) ? (72'(fr_q[idx_q]) <<< 14) : acc_q;
	assign tau_sum  = tau_base + prod_x;
	assign tau_r    = rnd(tau_sum, 14);

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_JRAW: begin
				op_a = 34'(dth);
				op_b = 34'sd1000;
			end
			S_JDIV, S_TDIV: begin
				op_a = signed'({1'b0, div_m});
				op_b = RECIP3_Q31;
			end
			S_FRU: begin
				op_a = 34'(w_q);
				op_b = fr_pos ? 34'(fp.vp) : (fr_neg ? 34'(fp.vn) : 34'(fp.slope));
			end
			S_FRH: begin
				op_a = 34'(signed'(u_q[46:24]));
				op_b = 34'(fp.coeff);
			end
			S_FRL: begin
				op_a = signed'({10'd0, u_q[23:0]});
				op_b = 34'(fp.coeff);
			end
			S_GEO: begin
				case (sub_q)
					G_TC: begin
						op_a = 34'(cs_q[0]);
						op_b = LINK_Q16;
					end
					G_TS: begin
						op_a = 34'(sn_q[0]);
						op_b = LINK_Q16;
					end
					G_P0: begin
						op_a = tc_q;
						op_b = 34'(sa);
					end
					G_P1: begin
						op_a = ts_q;
						op_b = 34'(sa);
					end
					G_P2: begin
						op_a = 34'(sb) + 34'sd32768;
						op_b = LINK_Q16;
					end
					G_J10: begin
						op_a = tc_q;
						op_b = 34'(sb);
					end
					G_J11: begin
						op_a = ts_q;
						op_b = 34'(sb);
					end
					G_J12: begin
						op_a = 34'(sa);
						op_b = LINK_Q16;
					end
					G_J20: begin
						op_a = tc_q;
						op_b = 34'(sn_q[2]);
					end
					G_J21: begin
						op_a = ts_q;
						op_b = 34'(sn_q[2]);
					end
					default: begin
						op_a = 34'(cs_q[2]);
						op_b = LINK_Q16;
					end
				endcase
			end
			S_TRAW: begin
				op_a = 34'(dtp);
				op_b = 34'sd500;
			end
			S_FP: begin
				op_a = 34'(dtg);
				op_b = signed'({18'd0, kp_v});
			end
			S_FD: begin
				op_a = 34'(dtv);
				op_b = signed'({17'd0, kd_v, 1'b0});
			end
			S_TAU: begin
				op_a = 34'(jt_v);
				op_b = 34'(f_q[sub_q[1:0]]);
			end
			default: ;
		endcase
	end

	assign mul_en     = !ph_q && (state_q != S_IDLE) && (state_q != S_CORD) &&
		(state_q != S_DONE);
	assign cord_start = (state_q == S_CORD) && !ph_q;
	assign load       = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Sequencer.
	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		idx_d   = idx_q;
		sub_d   = sub_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_JRAW;
					ph_d    = 1'b0;
					idx_d   = '0;
				end
			end
			S_JRAW, S_JDIV, S_FRU, S_FRH: begin
				ph_d = !ph_q;
				if (ph_q) begin
					state_d = state_q + 4'd1;
				end
			end
			S_FRL: begin
				ph_d = !ph_q;
				if (ph_q) begin
					if (idx_q == LAST_IDX) begin
						state_d = S_CORD;
						idx_d   = '0;
					end else begin
						state_d = S_JRAW;
						idx_d   = idx_q + 2'd1;
					end
				end
			end
			S_CORD: begin
				if (!ph_q) begin
					ph_d = 1'b1;
				end else if (cord.done) begin
					ph_d = 1'b0;
					if (idx_q == LAST_IDX) begin
						state_d = S_GEO;
						idx_d   = '0;
						sub_d   = G_TC;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
			end
			S_GEO: begin
				ph_d = !ph_q;
				if (ph_q) begin
					if (sub_q == G_J22) begin
						state_d = S_TRAW;
						idx_d   = '0;
					end else begin
						sub_d = sub_q + 4'd1;
					end
				end
			end
			S_TRAW, S_TDIV, S_FP: begin
				ph_d = !ph_q;
				if (ph_q) begin
					state_d = state_q + 4'd1;
				end
			end
			S_FD: begin
				ph_d = !ph_q;
				if (ph_q) begin
					if (idx_q == LAST_IDX) begin
						state_d = S_TAU;
						idx_d   = '0;
						sub_d   = '0;
					end else begin
						state_d = S_TRAW;
						idx_d   = idx_q + 2'd1;
					end
				end
			end
			S_TAU: begin
				ph_d = !ph_q;
				if (ph_q) begin
					if (sub_q == 4'(LAST_IDX)) begin
						sub_d = '0;
						if (idx_q == LAST_IDX) begin
							state_d = S_DONE;
						end else begin
							idx_d = idx_q + 2'd1;
						end
					end else begin
						sub_d = sub_q + 4'd1;
					end
				end
			end
			S_DONE: begin
				if (load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 1'b0;
			idx_q       <= '0;
			sub_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				lja_q[i] <= '0;
				jh0_q[i] <= '0;
				jh1_q[i] <= '0;
				ltp_q[i] <= '0;
				th0_q[i] <= '0;
				th1_q[i] <= '0;
			end
		end else begin
			state_q     <= state_d;
			ph_q        <= ph_d;
			idx_q       <= idx_d;
			sub_q       <= sub_d;
			out_valid_q <= load || (out_valid_q && out_stall);
			if (ph_q) begin
				unique case (state_q)
					S_JRAW: lja_q[idx_q] <= th_v[idx_q];
					S_JDIV: begin
						jh1_q[idx_q] <= jh0_q[idx_q];
						jh0_q[idx_q] <= div_w;
					end
					S_TRAW: ltp_q[idx_q] <= ps_v;
					S_TDIV: begin
						th1_q[idx_q] <= th0_q[idx_q];
						th0_q[idx_q] <= div_w;
					end
					default: ;
				endcase
			end
		end
	end

	// Datapath write-back.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q <= in_data;
		end
		if (load) begin
			out_q.torque_a <= tau_q[0];
			out_q.torque_b <= tau_q[1];
			out_q.torque_c <= tau_q[2];
			out_q.tip_x    <= sat16(p_q[0]);
			out_q.tip_y    <= sat16(p_q[1]);
			out_q.tip_z    <= sat16(p_q[2]);
		end
		if (state_q == S_CORD && ph_q && cord.done) begin
			sn_q[idx_q] <= cord.sin_val;
			cs_q[idx_q] <= cord.cos_val;
		end
		if (ph_q) begin
			unique case (state_q)
				S_JRAW: s_q <= 32'(prod) + jh0_q[idx_q] + jh1_q[idx_q];
				S_JDIV: w_q <= div_w;
				S_FRU:  u_q <= 47'(prod) + fr_cterm;
				S_FRH:  acc_q <= prod_x <<< 24;
				S_FRL:  fr_q[idx_q] <= 32'(rnd(acc_q + prod_x, 33));
				S_GEO: begin
					case (sub_q)
						G_TC:  tc_q     <= 34'(prod);
						G_TS:  ts_q     <= 34'(prod);
						G_P0:  p_q[0]   <= 18'(rnd(prod_x, 32));
						G_P1:  p_q[1]   <= 18'(rnd(prod_x, 32));
						G_P2:  p_q[2]   <= 18'(rnd(prod_x, 17));
						G_J10: jt1_q[0] <= 18'(rnd(prod_x, 32));
						G_J11: jt1_q[1] <= 18'(rnd(prod_x, 32));
						G_J12: jt1_q[2] <= -18'(rnd(prod_x, 17));
						G_J20: jt2_q[0] <= -18'(rnd(prod_x, 32));
						G_J21: jt2_q[1] <= -18'(rnd(prod_x, 32));
						default: jt2_q[2] <= -18'(rnd(prod_x, 17));
					endcase
				end
				S_TRAW: s_q <= 32'(prod) + th0_q[idx_q] + th1_q[idx_q];
				S_TDIV: v_q[idx_q] <= div_w;
				S_FP:   acc_q <= prod_x;
				S_FD: begin
					if (fd_r > 72'sd2147483647) begin
						f_q[idx_q] <= 32'sh7FFFFFFF;
					end else if (fd_r < -72'sd2147483648) begin
						f_q[idx_q] <= 32'sh80000000;
					end else begin
						f_q[idx_q] <= 32'(fd_r);
					end
				end
				S_TAU: begin
					if (sub_q == 4'(LAST_IDX)) begin
						if (tau_r > 72'(TORQUE_LIMIT)) begin
							tau_q[idx_q] <= TORQUE_LIMIT;
						end else if (tau_r < -72'(TORQUE_LIMIT)) begin
							tau_q[idx_q] <= -TORQUE_LIMIT;
						end else begin
							tau_q[idx_q] <= 16'(tau_r);
						end
					end else begin
						acc_q <= tau_sum;
					end
				end
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_JRAW && !ph_q)
		else $error("accepted request did not start the joint sequence");
	a_cord_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		cord.done |-> state_q == S_CORD && ph_q)
		else $error("CORDIC finished outside its wait step");
	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !ph_q && !mul_en)
		else $error("sequencer phase active while idle");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q && state_q == S_IDLE)
		else $error("loaded result not presented");
	a_torque_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.torque_a <= TORQUE_LIMIT && out_q.torque_a >= -TORQUE_LIMIT
			&& out_q.torque_b <= TORQUE_LIMIT && out_q.torque_b >= -TORQUE_LIMIT
			&& out_q.torque_c <= TORQUE_LIMIT && out_q.torque_c >= -TORQUE_LIMIT)
		else $error("torque result beyond saturation limit");
`endif

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the task-space PD controller with friction compensation
// Sends angle and target requests with random idling on both sides, predicts
// torques and tip positions from its own fixed-point model of the control
// law, and compares every result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;
	import tsp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_res_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	task_space_pd_with_friction_comp u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#10000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Predictor state: gains, angle and tip histories.
	longint gains [6];
	longint prev_angle [3];
	longint joint_hist [6];
	longint prev_tip [3];
	longint tip_hist [6];
	out_res_t torque_queue [$];
	int errors = 0;
	bit idle_send = 1'b1;
	bit idle_recv = 1'b1;
	bit hold_recv = 1'b0;

	function automatic longint floor_shift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint round_shift(longint v, int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint third(longint s);
		if (s >= 0)
			return (s + 1) / 3;
		return -((-s + 1) / 3);
	endfunction

	task automatic sin_cos(input longint ang, output longint s, output longint c);
		longint x, y, z, nx, at;
		bit flip;
		x = CORDIC_GAIN_Q30;
		y = 0;
		flip = 1'b0;
		if (ang > HALF_PI_Q13) begin
			ang -= PI_Q13;
			flip = 1'b1;
		end else if (ang < -HALF_PI_Q13) begin
			ang += PI_Q13;
			flip = 1'b1;
		end
		z = ang * 131072;
		for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
			at = longint'(atan_val(5'(i)));
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= at;
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += at;
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = round_shift(y, 15);
		c = round_shift(x, 15);
	endtask

	function automatic longint friction_torque(int j, longint w);
		longint thr, u;
		longint vp [3] = '{16469, 16384, 12596};
		longint vn [3] = '{16233, 18809, 13972};
		longint cp [3] = '{23835, 31189, 23075};
		longint cn [3] = '{19320, 32971, 23252};
		longint co [3] = '{58982, 49152, 65536};
		thr = (j == 0) ? 819 : 410;
		if (w > thr)
			u = w * vp[j] + cp[j] * 8192;
		else if (w < -thr)
			u = w * vn[j] - cn[j] * 8192;
		else
			u = w * 235930;
		return round_shift(u * co[j], 33);
	endfunction

	function automatic longint smooth(longint raw, ref longint h [6], input int k);
		longint w;
		w = third(raw + h[2 * k] + h[2 * k + 1]);
		h[2 * k + 1] = h[2 * k];
		h[2 * k] = w;
		return w;
	endfunction

	task automatic predict_torques(input in_req_t r);
		longint th [3], fr [3], sn [3], cs [3], p [3], v [3], f [3], jt [3][3];
		longint tg [3], tv [3], a, b, tau, L;
		out_res_t e;
		L = LINK_Q16;
		th = '{longint'(r.joint_angle_a), longint'(r.joint_angle_b),
			longint'(r.joint_angle_c)};
		tg = '{longint'(r.target_x), longint'(r.target_y), longint'(r.target_z)};
		tv = '{longint'(r.target_vel_x), longint'(r.target_vel_y),
			longint'(r.target_vel_z)};
		for (int j = 0; j < 3; j++) begin
			fr[j] = friction_torque(j, smooth((th[j] - prev_angle[j]) * 1000,
				joint_hist, j));
			prev_angle[j] = th[j];
			sin_cos(th[j], sn[j], cs[j]);
		end
		a = cs[2] + sn[1];
		b = cs[1] - sn[2];
		p[0] = round_shift(L * cs[0] * a, 32);
		p[1] = round_shift(L * sn[0] * a, 32);
		p[2] = round_shift(L * b + L * 32768, 17);
		jt[0][0] = -p[1];
		jt[0][1] = p[0];
		jt[0][2] = 0;
		jt[1][0] = round_shift(L * cs[0] * b, 32);
		jt[1][1] = round_shift(L * sn[0] * b, 32);
		jt[1][2] = -round_shift(L * a, 17);
		jt[2][0] = -round_shift(L * cs[0] * sn[2], 32);
		jt[2][1] = -round_shift(L * sn[0] * sn[2], 32);
		jt[2][2] = -round_shift(L * cs[2], 17);
		for (int k = 0; k < 3; k++) begin
			p[k] = clamp(p[k], -32768, 32767);
			v[k] = smooth((p[k] - prev_tip[k]) * 500, tip_hist, k);
			prev_tip[k] = p[k];
			f[k] = gains[k] * (tg[k] - p[k]) + 2 * gains[3 + k] * (tv[k] - v[k]);
			f[k] = clamp(round_shift(f[k], 10), -64'sd2147483648, 64'sd2147483647);
		end
		for (int j = 0; j < 3; j++) begin
			tau = fr[j] * 16384;
			for (int k = 0; k < 3; k++)
				tau += jt[j][k] * f[k];
			th[j] = clamp(round_shift(tau, 14), -TORQUE_LIMIT, TORQUE_LIMIT);
		end
		e.torque_a = 16'(th[0]);
		e.torque_b = 16'(th[1]);
		e.torque_c = 16'(th[2]);
		e.tip_x = 16'(p[0]);
		e.tip_y = 16'(p[1]);
		e.tip_z = 16'(p[2]);
		torque_queue.push_back(e);
	endtask

	task automatic send_request(input in_req_t r);
		int gap;
		if (idle_send && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_torques(r);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		while (torque_queue.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic write_gain(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		gains[idx] = longint'(val[15:0]);
		@(posedge clk);
	endtask

	function automatic in_req_t random_request();
		in_req_t r;
		r = in_req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		case ($urandom_range(0, 3))
			0: begin
				r.target_vel_x = 32'(int'($urandom_range(0, 20000)) - 10000);
				r.target_vel_y = 32'(int'($urandom_range(0, 20000)) - 10000);
				r.target_vel_z = 32'(int'($urandom_range(0, 20000)) - 10000);
			end
			1: begin
				r.joint_angle_a = 16'(prev_angle[0] + int'($urandom_range(0, 8)) - 4);
				r.joint_angle_b = 16'(prev_angle[1] + int'($urandom_range(0, 8)) - 4);
				r.joint_angle_c = 16'(prev_angle[2] + int'($urandom_range(0, 8)) - 4);
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (torque_queue.size() == 0) begin
				$display("%0t unexpected result %h", $time, out_data);
				errors++;
			end else begin
				out_res_t e;
				e = torque_queue.pop_front();
				if (e.torque_a !== out_data.torque_a)
					$display("%0t torque_a exp %0d got %0d", $time, e.torque_a,
						out_data.torque_a);
				if (e.torque_b !== out_data.torque_b)
					$display("%0t torque_b exp %0d got %0d", $time, e.torque_b,
						out_data.torque_b);
				if (e.torque_c !== out_data.torque_c)
					$display("%0t torque_c exp %0d got %0d", $time, e.torque_c,
						out_data.torque_c);
				if (e.tip_x !== out_data.tip_x)
					$display("%0t tip_x exp %0d got %0d", $time, e.tip_x, out_data.tip_x);
				if (e.tip_y !== out_data.tip_y)
					$display("%0t tip_y exp %0d got %0d", $time, e.tip_y, out_data.tip_y);
				if (e.tip_z !== out_data.tip_z)
					$display("%0t tip_z exp %0d got %0d", $time, e.tip_z, out_data.tip_z);
				if (e !== out_data)
					errors++;
			end
		end
	end

	// Receiver stall: random bursts, or a long hold when requested.
	always @(posedge clk) begin
		int burst;
		if (hold_recv) begin
			out_stall <= 1'b1;
		end else if (idle_recv && $urandom_range(0, 99) < 3) begin
			burst = $urandom_range(1, 18);
			out_stall <= 1'b1;
			repeat (burst) @(posedge clk);
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic test_extremes();
		in_req_t r;
		logic [15:0] a16 [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h3244,
			16'hCDBC};
		for (int i = 0; i < 6; i++) begin
			r.joint_angle_a = a16[i];
			r.joint_angle_b = a16[(i + 1) % 6];
			r.joint_angle_c = a16[(i + 2) % 6];
			r.target_x = a16[(i + 3) % 6];
			r.target_y = a16[(i + 4) % 6];
			r.target_z = a16[(i + 5) % 6];
			r.target_vel_x = (i % 2) ? 32'h7FFFFFFF : 32'h80000000;
			r.target_vel_y = (i % 3 == 0) ? 32'h80000000 : 32'hFFFFFFFF;
			r.target_vel_z = (i % 2) ? 32'h00000000 : 32'h7FFFFFFF;
			send_request(r);
		end
	endtask

	task automatic test_friction_bands();
		in_req_t r;
		int steps [8] = '{0, 1, -1, 2, -2, 5, -5, 0};
		r = '0;
		for (int i = 0; i < 8; i++) begin
			r.joint_angle_a = 16'(prev_angle[0] + steps[i]);
			r.joint_angle_b = 16'(prev_angle[1] - steps[i]);
			r.joint_angle_c = 16'(prev_angle[2] + 2 * steps[i]);
			send_request(r);
		end
	endtask

	task automatic test_gain_settings();
		logic [31:0] val;
		for (int phase = 0; phase < 4; phase++) begin
			wait_drained();
			for (int g = 0; g < 6; g++) begin
				val = phase == 0 ? 32'hFFFF0000 : phase == 1 ? 32'h0001FFFF :
					{16'($urandom_range(0, 65535)), 16'($urandom)};
				write_gain(3'(g), val);
			end
			for (int i = 0; i < 150; i++)
				send_request(random_request());
		end
		wait_drained();
		write_gain(REG_GAIN_P_X, 32'd25600);
		write_gain(REG_GAIN_P_Y, 32'd51200);
		write_gain(REG_GAIN_P_Z, 32'd51200);
		write_gain(REG_GAIN_D_X, 32'd1024);
		write_gain(REG_GAIN_D_Y, 32'd1536);
		write_gain(REG_GAIN_D_Z, 32'd1536);
	endtask

	task automatic test_backpressure();
		hold_recv = 1'b1;
		fork
			begin
				repeat (800) @(posedge clk);
				hold_recv = 1'b0;
			end
			for (int i = 0; i < 8; i++)
				send_request(random_request());
		join
		wait_drained();
	endtask

	task automatic test_random_run();
		for (int i = 0; i < 1000; i++)
			send_request(random_request());
		idle_send = 1'b0;
		idle_recv = 1'b0;
		for (int i = 0; i < 250; i++)
			send_request(random_request());
	endtask

	initial begin
		gains = '{25600, 51200, 51200, 1024, 1536, 1536};
		prev_angle = '{0, 0, 0};
		prev_tip = '{0, 0, 0};
		joint_hist = '{0, 0, 0, 0, 0, 0};
		tip_hist = '{0, 0, 0, 0, 0, 0};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_friction_bands();
		test_backpressure();
		test_gain_settings();
		test_random_run();
		wait_drained();
		if (errors == 0 && torque_queue.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
sv/tsp_pkg.sv
sv/tsp_mul.sv
sv/tsp_cordic.sv
sv/tsp_cfg.sv
sv/task_space_pd_with_friction_comp.sv
bench/tb.sv
